FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: design/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// shared types and constants of the character class tokenizer
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int         MAX_RES    = 4;
    localparam int         NUM_MAPS   = 8;
    localparam longint     MAX_TEXT   = 65536;
    localparam logic [15:0] POS_CAP   =
        (MAX_TEXT - 1 < 65535) ? 16'(MAX_TEXT - 1) : 16'hFFFF;

    localparam logic [NUM_MAPS-1:0][63:0] MAP_RESET = {
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd2, 64'd204996608
    };

    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_BREAK = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] CLS_WORD   = 2'd0;
    localparam logic [1:0] CLS_BREAK  = 2'd1;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NL      = 8'h0A;

    typedef logic [255:0][1:0] class_map_t;

    typedef struct packed {
        logic        overflow;
        logic        end_of_text;
        logic [1:0]  token_kind;
        logic [15:0] token_length;
        logic [15:0] token_start;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic [2:0]            count;
    } bundle_t;

endpackage

FILE: design/cct_scan.sv
// ----------------------------------------------------------------------------
// cct_scan
// scanner state and per-byte token decisions, one byte per accepted item
// ----------------------------------------------------------------------------
module cct_scan import cct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    input  class_map_t class_map,
    output bundle_t    bundle
);

    typedef enum logic [2:0] {
        CM_OUT   = 3'b001,
        CM_LINE  = 3'b010,
        CM_BLOCK = 3'b100
    } cmode_t;

    typedef struct packed {
        logic                  in_word;
        logic [15:0]           wb;
        result_t [MAX_RES-1:0] res;
        logic [2:0]            n;
    } scan_t;

    logic [15:0] pos_reg, pos_next;
    cmode_t      cm_reg, cm_next;
    logic        slash_reg, slash_next;
    logic        star_reg, star_next;
    logic        in_word_reg;
    logic [15:0] wb_reg;
    logic        ovf_reg, ovf_next;
    scan_t       st;

    function automatic logic [15:0] next_pos(logic [15:0] p);
        return (p < POS_CAP) ? p + 16'd1 : POS_CAP;
    endfunction

    function automatic scan_t push(scan_t s, logic [15:0] start, logic [15:0] len,
                                   logic [1:0] kind);
        scan_t r;
        r = s;
        if (s.n < 3'(MAX_RES)) begin
            r.res[s.n[1:0]] = '{overflow: 1'b0, end_of_text: (kind == KIND_END),
                               token_kind: kind, token_length: len, token_start: start};
            r.n = s.n + 3'd1;
        end
        return r;
    endfunction

    function automatic scan_t close_word(scan_t s, logic [16:0] stop);
        scan_t       r;
        logic [16:0] len17;
        logic [15:0] len16;
        r = s;
        if (s.in_word) begin
            len17 = (stop >= {1'b0, s.wb}) ? stop - {1'b0, s.wb} : 17'd0;
            len16 = len17[16] ? 16'hFFFF : len17[15:0];
            r = push(r, s.wb, len16, KIND_WORD);
            r.in_word = 1'b0;
        end
        return r;
    endfunction

    function automatic scan_t take_normal(scan_t s, logic [1:0] k, logic [15:0] q);
        scan_t r;
        r = s;
        if (k == CLS_WORD) begin
            if (!s.in_word) begin
                r.in_word = 1'b1;
                r.wb      = q;
            end
        end else begin
            r = close_word(s, {1'b0, q});
            if (k == CLS_BREAK) begin
                r = push(r, q, 16'd1, KIND_BREAK);
            end
        end
        return r;
    endfunction

    always_comb begin
        logic        outside;
        logic        hold;
        logic [15:0] p;
        logic [1:0]  cls_b;
        logic [1:0]  cls_slash;
        outside    = (cm_reg != CM_LINE) && (cm_reg != CM_BLOCK);
        p          = (outside && slash_reg) ? next_pos(pos_reg) : pos_reg;
        cls_b      = class_map[text_byte];
        cls_slash  = class_map[CH_SLASH];
        hold       = 1'b0;
        ovf_next   = ovf_reg | (p >= POS_CAP);
        cm_next    = cm_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        st         = '0;
        st.in_word = in_word_reg;
        st.wb      = wb_reg;

        if (cm_reg == CM_LINE) begin
            if (text_byte == CH_NL) begin
                cm_next = CM_OUT;
                st      = take_normal(st, cls_b, p);
            end
        end else if (cm_reg == CM_BLOCK) begin
            if (star_reg && text_byte == CH_SLASH) begin
                cm_next   = CM_OUT;
                star_next = 1'b0;
            end else begin
                star_next = (text_byte == CH_STAR);
            end
        end else begin
            cm_next = CM_OUT;
            if (slash_reg) begin
                slash_next = 1'b0;
                if (text_byte == CH_SLASH || text_byte == CH_STAR) begin
                    st        = close_word(st, {1'b0, pos_reg});
                    cm_next   = (text_byte == CH_SLASH) ? CM_LINE : CM_BLOCK;
                    star_next = 1'b0;
                end else begin
                    st = take_normal(st, cls_slash, pos_reg);
                    st = take_normal(st, cls_b, p);
                end
            end else if (text_byte == CH_SLASH) begin
                slash_next = 1'b1;
                hold       = 1'b1;
            end else begin
                st = take_normal(st, cls_b, p);
            end
        end

        pos_next = hold ? p : next_pos(p);

        if (final_byte) begin
            if (slash_next) begin
                st = take_normal(st, cls_slash, p);
            end
            st = close_word(st, {1'b0, p} + 17'd1);
            st = push(st, next_pos(p), 16'd0, KIND_END);
        end

        for (int i = 0; i < MAX_RES; i++) begin
            st.res[i].overflow = ovf_next;
        end

        bundle.res   = st.res;
        bundle.count = st.n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            cm_reg      <= CM_OUT;
            slash_reg   <= 1'b0;
            star_reg    <= 1'b0;
            in_word_reg <= 1'b0;
            wb_reg      <= '0;
            ovf_reg     <= 1'b0;
        end else if (advance) begin
            if (final_byte) begin
                pos_reg     <= '0;
                cm_reg      <= CM_OUT;
                slash_reg   <= 1'b0;
                star_reg    <= 1'b0;
                in_word_reg <= 1'b0;
                wb_reg      <= '0;
                ovf_reg     <= 1'b0;
            end else begin
                pos_reg     <= pos_next;
                cm_reg      <= cm_next;
                slash_reg   <= slash_next;
                star_reg    <= star_next;
                in_word_reg <= st.in_word;
                wb_reg      <= st.wb;
                ovf_reg     <= ovf_next;
            end
        end
    end

endmodule

FILE: design/char_class_tokenizer_core.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer_core
// byte stream tokenizer with class map and comment skipping
// ----------------------------------------------------------------------------
// One text byte is taken per cycle unless s_tready is low. Each byte yields
// zero to four tokens into a four-slot result buffer, which sends out one item
// per cycle while m_tready is high; a byte yielding k tokens (k >= 2) holds the
// slave side until one is left and m_tready is high, so other bytes stream at
// full rate. A token shows in the cycle after its byte is taken; the end marker
// of each text carries tlast. The user must write the class map registers
// through the cfg port only while the stream is idle; the core does not check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_class_tokenizer_core import cct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // text_byte
    input  logic        s_tlast,     // final_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // token_start, token_length, overflow, zero pad
    output logic [1:0]  m_tuser,     // token_kind
    output logic        m_tlast      // end_of_text
);

    logic [NUM_MAPS-1:0][63:0] map_reg;
    result_t [MAX_RES-1:0]     slot_reg;
    logic [2:0]                cnt_reg;
    bundle_t                   bundle;
    logic                      s_fire;
    logic                      m_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= MAP_RESET;
        end else if (cfg_we) begin
            map_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);

    cct_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_fire),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .class_map  (class_map_t'(map_reg)),
        .bundle     (bundle)
    );

    // result buffer, slot 0 is always the head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_fire) begin
            cnt_reg <= bundle.count;
        end else if (m_fire) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            slot_reg <= bundle.res;
        end else if (m_fire) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {7'd0, slot_reg[0].overflow, slot_reg[0].token_length,
                       slot_reg[0].token_start};
    assign m_tuser  = slot_reg[0].token_kind;
    assign m_tlast  = slot_reg[0].end_of_text;

    `ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > 3'(MAX_RES))
    `ASSERT_HOLDS(a_end_is_last, aclk, aresetn, (m_tvalid && m_tlast) |-> (cnt_reg == 3'd1))
    `ASSERT_HOLDS(a_last_kind, aclk, aresetn, m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
    `ASSERT_HOLDS(a_break_len, aclk, aresetn, (m_tvalid && m_tuser == KIND_BREAK) |-> (m_tdata[31:16] == 16'd1))

endmodule

FILE: bench/tb_char_class_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_char_class_tokenizer_core
// self-checking bench for the character class tokenizer core
// ----------------------------------------------------------------------------
// Text bytes are queued by phase and streamed in by a clocked driver. Each
// accepted byte is run through a local tokenizer model which queues the tokens
// it should cause. A monitor checks every token leaving the core against the
// oldest queued one. The class maps are rewritten between phases (source-like,
// random, all word, all class 3, all breaker, all blank). A directed opening
// covers comment corner cases.
// ----------------------------------------------------------------------------
module tb_char_class_tokenizer_core;
    import cct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [1:0]  MODE_OUT      = 2'd0;
    localparam logic [1:0]  MODE_LINE     = 2'd1;
    localparam logic [1:0]  MODE_BLOCK    = 2'd2;
    localparam logic [1:0]  CLS_BLANK     = 2'd2;

    typedef enum int {
        MAPS_SOURCE, MAPS_RANDOM, MAPS_ALL_WORD, MAPS_ALL_NL, MAPS_ALL_BREAK, MAPS_ALL_BLANK
    } map_style_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } text_unit_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // model state
    logic [63:0] map_reg [NUM_MAPS];
    int unsigned pos_r;
    int unsigned word_beg_r;
    logic [1:0]  mode_r;
    bit          slash_r;
    bit          star_r;
    bit          word_r;
    bit          ovf_r;

    result_t     fresh_q[$];
    result_t     pending_tokens[$];
    text_unit_t  text_q[$];
    string       punct_set = ",;()+-=<>{}[]*/";

    int          send_idle_pct = 16;
    int          sink_idle_pct = 77;
    int          queued_bytes  = 0;
    int          bytes_taken   = 0;
    int          texts_done    = 0;
    int          word_tokens   = 0;
    int          break_tokens  = 0;
    int          drain_pauses  = 0;
    int          mismatches    = 0;
    int          cycles        = 0;
    bit          drain_hold    = 1'b0;

    char_class_tokenizer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // tokenizer model
    // ------------------------------------------------------------------
    function automatic int unsigned step_pos(int unsigned p);
        return (p < POS_CAP) ? p + 1 : POS_CAP;
    endfunction

    function automatic logic [1:0] class_of(logic [7:0] b);
        return map_reg[b[7:5]][2 * b[4:0] +: 2];
    endfunction

    function automatic void clear_text_state();
        pos_r      = 0;
        word_beg_r = 0;
        mode_r     = MODE_OUT;
        slash_r    = 1'b0;
        star_r     = 1'b0;
        word_r     = 1'b0;
        ovf_r      = 1'b0;
    endfunction

    task automatic push_token(int unsigned start, int unsigned len, logic [1:0] kind);
        result_t r;
        r.token_start  = start[15:0];
        r.token_length = (len > 65535) ? 16'hFFFF : len[15:0];
        r.token_kind   = kind;
        r.end_of_text  = (kind == KIND_END);
        r.overflow     = 1'b0;
        fresh_q.push_back(r);
        if (kind == KIND_WORD) word_tokens++;
        if (kind == KIND_BREAK) break_tokens++;
    endtask

    task automatic close_run(int unsigned stop);
        if (word_r) begin
            push_token(word_beg_r, (stop >= word_beg_r) ? stop - word_beg_r : 0, KIND_WORD);
            word_r = 1'b0;
        end
    endtask

    task automatic take_class(logic [7:0] c, int unsigned q);
        logic [1:0] k;
        k = class_of(c);
        if (k == CLS_WORD) begin
            if (!word_r) begin
                word_r     = 1'b1;
                word_beg_r = q;
            end
        end else begin
            close_run(q);
            if (k == CLS_BREAK) push_token(q, 1, KIND_BREAK);
        end
    endtask

    task automatic tokenize_byte(logic [7:0] b, logic fin);
        int unsigned held;
        int unsigned p;
        bit          hold;
        result_t     r;
        held = pos_r;
        p    = pos_r;
        hold = 1'b0;
        if (mode_r != MODE_LINE && mode_r != MODE_BLOCK && slash_r) p = step_pos(held);
        if (p >= POS_CAP) ovf_r = 1'b1;
        if (mode_r == MODE_LINE) begin
            if (b == CH_NL) begin
                mode_r = MODE_OUT;
                take_class(b, p);
            end
        end else if (mode_r == MODE_BLOCK) begin
            if (star_r && b == CH_SLASH) begin
                mode_r = MODE_OUT;
                star_r = 1'b0;
            end else begin
                star_r = (b == CH_STAR);
            end
        end else begin
            mode_r = MODE_OUT;
            if (slash_r) begin
                slash_r = 1'b0;
                if (b == CH_SLASH || b == CH_STAR) begin
                    close_run(held);
                    mode_r = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    star_r = 1'b0;
                end else begin
                    take_class(CH_SLASH, held);
                    take_class(b, p);
                end
            end else if (b == CH_SLASH) begin
                slash_r = 1'b1;
                hold    = 1'b1;
            end else begin
                take_class(b, p);
            end
        end
        pos_r = hold ? p : step_pos(p);
        if (fin) begin
            if (slash_r) begin
                slash_r = 1'b0;
                take_class(CH_SLASH, p);
            end
            close_run(p + 1);
            push_token(step_pos(p), 0, KIND_END);
        end
        while (fresh_q.size() != 0) begin
            r = fresh_q.pop_front();
            r.overflow = ovf_r;
            pending_tokens.push_back(r);
        end
        if (fin) begin
            texts_done++;
            clear_text_state();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b, logic last);
        text_q.push_back({b, last});
        queued_bytes++;
    endtask

    task automatic queue_literal(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] mixed_byte();
        case ($urandom_range(6))
            0: return 8'(8'h61 + $urandom_range(25));
            1: return punct_set[$urandom_range(punct_set.len() - 1)];
            2: return 8'h20;
            3: return CH_NL;
            4: return CH_SLASH;
            5: return CH_STAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_text(int pieces);
        logic [7:0] frag[$];
        logic [7:0] c;
        int         n;
        for (int k = 0; k < pieces; k++) begin
            case ($urandom_range(8))
                0: begin
                    n = $urandom_range(1, 6);
                    repeat (n) frag.push_back(8'(8'h61 + $urandom_range(25)));
                end
                1: frag.push_back(punct_set[$urandom_range(punct_set.len() - 1)]);
                2: frag.push_back(8'h20);
                3: frag.push_back(CH_NL);
                4: begin
                    frag.push_back(CH_SLASH);
                    frag.push_back(CH_SLASH);
                    repeat ($urandom_range(5)) begin
                        c = mixed_byte();
                        frag.push_back((c == CH_NL) ? CH_STAR : c);
                    end
                    if ($urandom_range(7) != 0) frag.push_back(CH_NL);
                end
                5: begin
                    frag.push_back(CH_SLASH);
                    frag.push_back(CH_STAR);
                    repeat ($urandom_range(5)) frag.push_back(mixed_byte());
                    if ($urandom_range(7) != 0) begin
                        frag.push_back(CH_STAR);
                        frag.push_back(CH_SLASH);
                    end
                end
                6: begin
                    // opener star followed by slash must not close
                    frag.push_back(CH_SLASH);
                    frag.push_back(CH_STAR);
                    frag.push_back(CH_SLASH);
                    frag.push_back(8'(8'h61 + $urandom_range(25)));
                    frag.push_back(CH_STAR);
                    frag.push_back(CH_SLASH);
                end
                7: begin
                    frag.push_back(CH_SLASH);
                    frag.push_back(mixed_byte());
                end
                default: frag.push_back(mixed_byte());
            endcase
        end
        for (int k = 0; k < frag.size(); k++) push_byte(frag[k], k == frag.size() - 1);
    endtask

    task automatic queue_random_texts(int target);
        int goal;
        int n;
        goal = queued_bytes + target;
        while (queued_bytes < goal) begin
            if ($urandom_range(9) < 8) begin
                queue_text($urandom_range(1, 6));
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    push_byte(8'($urandom_range(255)),
                              (k == n - 1) || ($urandom_range(7) == 0));
            end
        end
    endtask

    task automatic apply_maps(map_style_t style);
        logic [63:0] img;
        logic [7:0]  c;
        for (int r = 0; r < NUM_MAPS; r++) begin
            case (style)
                MAPS_SOURCE:    img = MAP_RESET[r];
                MAPS_RANDOM:    img = {$urandom, $urandom};
                MAPS_ALL_WORD:  img = '0;
                MAPS_ALL_NL:    img = '1;
                MAPS_ALL_BREAK: img = {32{CLS_BREAK}};
                default:        img = {32{CLS_BLANK}};
            endcase
            map_reg[r] = img;
        end
        if (style == MAPS_SOURCE) begin
            for (int i = 0; i < punct_set.len(); i++) begin
                c = punct_set[i];
                map_reg[c[7:5]][2 * c[4:0] +: 2] = CLS_BREAK;
            end
        end
        for (int r = 0; r < NUM_MAPS; r++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(r);
            cfg_wdata <= map_reg[r];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (bytes_taken != queued_bytes || pending_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        text_unit_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tokenize_byte(s_tdata, s_tlast);
                bytes_taken++;
                if (s_tlast && (drain_pauses == 0 || $urandom_range(3) == 0)) drain_hold = 1'b1;
            end
            if (drain_hold && pending_tokens.size() == 0) begin
                drain_hold = 1'b0;
                drain_pauses++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (text_q.size() != 0 && !drain_hold &&
                         $urandom_range(99) >= send_idle_pct) begin
                cur = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur.value;
                s_tlast  <= cur.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.token_start  = m_tdata[15:0];
            got.token_length = m_tdata[31:16];
            got.overflow     = m_tdata[32];
            got.token_kind   = m_tuser;
            got.end_of_text  = m_tlast;
            if (pending_tokens.size() == 0) begin
                if (mismatches < 10)
                    $display("token with none expected: start %0d len %0d kind %0d",
                             got.token_start, got.token_length, got.token_kind);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want || m_tdata[39:33] !== '0) begin
                    if (mismatches < 10) begin
                        $display("token mismatch: expected start %0d len %0d kind %0d end %0b ovf %0b",
                                 want.token_start, want.token_length, want.token_kind,
                                 want.end_of_text, want.overflow);
                        $display("  got start %0d len %0d kind %0d end %0b ovf %0b pad %0h",
                                 got.token_start, got.token_length, got.token_kind,
                                 got.end_of_text, got.overflow, m_tdata[39:33]);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d tokens outstanding", pending_tokens.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // phases
    // ------------------------------------------------------------------
    initial begin
        for (int r = 0; r < NUM_MAPS; r++) map_reg[r] = MAP_RESET[r];
        clear_text_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // power-on maps: comments, word at start, word after closer, held slash
        queue_literal("a/*/b*/c d,//x\nz");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_SLASH, 1'b1);
        queue_literal("/q");
        queue_literal("/*k");
        queue_literal(" ");
        wait_idle();

        apply_maps(MAPS_SOURCE);
        queue_random_texts(85);
        wait_idle();

        send_idle_pct = 77;
        sink_idle_pct = 16;
        apply_maps(MAPS_RANDOM);
        queue_random_texts(40);
        wait_idle();
        apply_maps(MAPS_RANDOM);
        queue_random_texts(35);
        wait_idle();
        apply_maps(MAPS_ALL_WORD);
        queue_random_texts(30);
        wait_idle();

        send_idle_pct = 0;
        sink_idle_pct = 0;
        apply_maps(MAPS_ALL_NL);
        queue_random_texts(25);
        wait_idle();
        apply_maps(MAPS_ALL_BREAK);
        queue_random_texts(35);
        wait_idle();
        apply_maps(MAPS_ALL_BLANK);
        queue_random_texts(30);
        wait_idle();

        $display("covered %0d bytes in %0d texts over 8 map settings", bytes_taken, texts_done);
        $display("checked %0d word and %0d breaker tokens, %0d drain pauses",
                 word_tokens, break_tokens, drain_pauses);
        if (mismatches == 0 && pending_tokens.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
